/* rtl/tpe_pkg.sv */
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared constants, register indexes, the derived-value bundle and the
// saturating helpers used by the trapezoid profile evaluator.
// ----------------------------------------------------------------------------
package tpe_pkg;

   // default number of fraction bits in every fixed-point value
   localparam int unsigned FRAC_BITS_DEF = 16;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_START_POS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_END_POS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL     = 3'd3;

   // reset value of both limits
   localparam logic [30:0] LIMIT_RESET = 31'd65536;

   // values worked out once per configuration
   typedef struct packed {
      logic [31:0] travel;
      logic [31:0] ramp;
      logic [31:0] total;
      logic [31:0] cruise_end;
      logic [31:0] span;
      logic        dir;
      logic        cruise;
      logic        ready;
   } derived_type;

   // 64-bit add that sticks at all ones on overflow
   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // exact product shifted right, saturated to 64 bits
   function automatic logic [63:0] mul_shift(input logic [95:0] p, input int unsigned s);
      logic [95:0] hi;
      logic [95:0] sh;
      hi = p >> (64 + s);
      sh = p >> s;
      return (hi != '0) ? {64{1'b1}} : sh[63:0];
   endfunction

endpackage

/* rtl/tpe_derive.sv */
// ----------------------------------------------------------------------------
// tpe_derive
// Sequencer that works out distance, direction, ramp time and total time
// from the configuration, using a bit-serial divider and square root.
// ----------------------------------------------------------------------------
module tpe_derive import tpe_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic signed [31:0] start_pos,
   input  logic signed [31:0] end_pos,
   input  logic        [30:0] v_eff,
   input  logic        [30:0] a_eff,
   output derived_type        drv
);

   localparam int unsigned DVW = 32 + FRAC_BITS;
   localparam int unsigned DCW = $clog2(DVW + 1);
   localparam logic [63:0] SQ_LIMIT = 64'd1 << (62 - FRAC_BITS);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_DIV1 = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_CMP  = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_SQRT = 3'd5;
   localparam logic [2:0] ST_FIN  = 3'd6;
   localparam logic [2:0] ST_IDLE = 3'd7;

   logic [2:0]     state_ff, state_in;
   logic [DVW-1:0] div_q_ff, div_q_in;
   logic [31:0]    div_rem_ff, div_rem_in;
   logic [30:0]    div_dvs_ff, div_dvs_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [63:0]    sq_x_ff, sq_x_in;
   logic [63:0]    sq_r_ff, sq_r_in;
   logic [63:0]    sq_bit_ff, sq_bit_in;
   logic [5:0]     sq_cnt_ff, sq_cnt_in;
   logic [62:0]    prod_da_ff, prod_da_in;
   logic [61:0]    prod_vv_ff, prod_vv_in;
   derived_type    drv_ff, drv_in;

   // one restoring divider step
   logic [31:0]    rem_sh;
   logic           div_ge;
   logic [31:0]    rem_step;
   logic [DVW-1:0] q_step;

   assign rem_sh   = {div_rem_ff[30:0], div_q_ff[DVW-1]};
   assign div_ge   = rem_sh >= {1'b0, div_dvs_ff};
   assign rem_step = div_ge ? (rem_sh - {1'b0, div_dvs_ff}) : rem_sh;
   assign q_step   = {div_q_ff[DVW-2:0], div_ge};

   // one square root step
   logic [63:0] sq_sum;
   logic        sq_ge;

   assign sq_sum = sq_r_ff + sq_bit_ff;
   assign sq_ge  = sq_x_ff >= sq_sum;

   // sequencer
   always_comb begin
      logic signed [32:0] diff;
      logic        [32:0] mag;
      logic               cruise;
      logic [DVW:0]       tsum;
      logic [32:0]        two_r;
      state_in   = state_ff;
      div_q_in   = div_q_ff;
      div_rem_in = div_rem_ff;
      div_dvs_in = div_dvs_ff;
      div_cnt_in = div_cnt_ff;
      sq_x_in    = sq_x_ff;
      sq_r_in    = sq_r_ff;
      sq_bit_in  = sq_bit_ff;
      sq_cnt_in  = sq_cnt_ff;
      prod_da_in = prod_da_ff;
      prod_vv_in = prod_vv_ff;
      drv_in     = drv_ff;
      diff   = {end_pos[31], end_pos} - {start_pos[31], start_pos};
      mag    = diff[32] ? (33'd0 - diff) : diff;
      cruise = prod_da_ff > {1'b0, prod_vv_ff};
      tsum   = (DVW+1)'(drv_ff.ramp) + {1'b0, div_q_ff};
      two_r  = {drv_ff.ramp, 1'b0};
      unique case (state_ff)
         ST_INIT: begin
            drv_in.ready  = 1'b0;
            drv_in.dir    = diff[32];
            drv_in.travel = mag[31:0];
            div_q_in      = DVW'({v_eff, {FRAC_BITS{1'b0}}});
            div_rem_in    = '0;
            div_dvs_in    = a_eff;
            div_cnt_in    = DCW'(DVW);
            state_in      = ST_DIV1;
         end
         ST_DIV1: begin
            if (div_cnt_ff != '0) begin
               div_q_in   = q_step;
               div_rem_in = rem_step;
               div_cnt_in = div_cnt_ff - 1'b1;
            end else begin
               drv_in.ramp = (div_q_ff > DVW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                              : div_q_ff[31:0];
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_da_in = 63'(drv_ff.travel) * 63'(a_eff);
            prod_vv_in = 62'(v_eff) * 62'(v_eff);
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            drv_in.cruise = cruise;
            div_q_in      = {drv_ff.travel, {FRAC_BITS{1'b0}}};
            div_rem_in    = '0;
            div_dvs_in    = cruise ? v_eff : a_eff;
            div_cnt_in    = DCW'(DVW);
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            if (div_cnt_ff != '0) begin
               div_q_in   = q_step;
               div_rem_in = rem_step;
               div_cnt_in = div_cnt_ff - 1'b1;
            end else if (drv_ff.cruise) begin
               drv_in.total = (tsum > (DVW+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                               : tsum[31:0];
               state_in     = ST_FIN;
            end else if (64'(div_q_ff) >= SQ_LIMIT) begin
               drv_in.total = 32'hFFFF_FFFF;
               state_in     = ST_FIN;
            end else begin
               sq_x_in   = 64'(div_q_ff) << FRAC_BITS;
               sq_r_in   = '0;
               sq_bit_in = 64'd1 << 62;
               sq_cnt_in = 6'd32;
               state_in  = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_cnt_ff != '0) begin
               if (sq_ge) begin
                  sq_x_in = sq_x_ff - sq_sum;
                  sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_in = sq_r_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
               sq_cnt_in = sq_cnt_ff - 1'b1;
            end else begin
               drv_in.total = {sq_r_ff[30:0], 1'b0};
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            drv_in.cruise_end = (drv_ff.total >= drv_ff.ramp) ? (drv_ff.total - drv_ff.ramp)
                                                              : 32'd0;
            drv_in.span       = ({1'b0, drv_ff.total} >= two_r)
                                ? 32'({1'b0, drv_ff.total} - two_r) : 32'd0;
            drv_in.ready      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
      // a register write starts the work again
      if (restart) begin
         drv_in.ready = 1'b0;
         state_in     = ST_INIT;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         drv_ff     <= '0;
         div_cnt_ff <= '0;
         sq_cnt_ff  <= '0;
         sq_bit_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         drv_ff     <= drv_in;
         div_cnt_ff <= div_cnt_in;
         sq_cnt_ff  <= sq_cnt_in;
         sq_bit_ff  <= sq_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff   <= div_q_in;
      div_rem_ff <= div_rem_in;
      div_dvs_ff <= div_dvs_in;
      sq_x_ff    <= sq_x_in;
      sq_r_ff    <= sq_r_in;
      prod_da_ff <= prod_da_in;
      prod_vv_ff <= prod_vv_in;
   end

   assign drv = drv_ff;

   // checks
   a_ready_idle : assert property (@(posedge clock) disable iff (reset)
      drv_ff.ready |-> state_ff == ST_IDLE)
      else $error("derived values marked ready outside idle");
   a_sq_bit : assert property (@(posedge clock) disable iff (reset)
      $onehot0(sq_bit_ff))
      else $error("square root bit not one-hot");
   a_div_cnt : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV1 || state_ff == ST_DIV2) |-> div_cnt_ff <= DCW'(DVW))
      else $error("divider count out of range");

endmodule

/* rtl/tpe_eval.sv */
// ----------------------------------------------------------------------------
// tpe_eval
// Seven-stage pipeline that turns a sample time into position, velocity
// and acceleration, one beat per cycle.
// ----------------------------------------------------------------------------
module tpe_eval import tpe_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] in_time,
   input  derived_type        drv,
   input  logic        [30:0] a_eff,
   input  logic        [30:0] v_eff,
   input  logic signed [31:0] start_pos,
   input  logic signed [31:0] end_pos,
   output logic               out_valid,
   output logic signed [31:0] out_position,
   output logic signed [31:0] out_velocity,
   output logic signed [31:0] out_acceleration
);

   localparam logic [1:0] KIND_RUN   = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   localparam logic [1:0] PH_UP   = 2'd0;
   localparam logic [1:0] PH_MID  = 2'd1;
   localparam logic [1:0] PH_DOWN = 2'd2;

   localparam logic [33:0] DISP_MAX = 34'h2_0000_0000;

   // stage a: classify
   logic        a_valid_ff;
   logic [1:0]  a_kind_ff, a_kind_in;
   logic [1:0]  a_phase_ff, a_phase_in;
   logic [31:0] a_x_ff, a_x_in;
   logic [31:0] a_y_ff, a_y_in;
   logic [31:0] a_b_ff, a_b_in;
   logic [31:0] a_w1_ff, a_w1_in;
   logic [31:0] a_w2_ff, a_w2_in;

   always_comb begin
      logic [31:0] ut;
      logic [31:0] h;
      ut         = in_time;
      h          = {1'b0, drv.total[31:1]};
      a_x_in     = '0;
      a_y_in     = '0;
      a_w1_in    = '0;
      a_w2_in    = '0;
      a_phase_in = PH_UP;
      if (in_time[31] || in_time == '0) begin
         a_kind_in = KIND_START;
      end else if (ut >= drv.total) begin
         a_kind_in = KIND_END;
      end else begin
         a_kind_in = KIND_RUN;
      end
      if (drv.cruise) begin
         a_b_in = drv.ramp;
         if (ut <= drv.ramp) begin
            a_x_in = ut;
            a_y_in = ut;
         end else if (ut <= drv.cruise_end) begin
            a_phase_in = PH_MID;
            a_w1_in    = ut - drv.ramp;
         end else begin
            a_phase_in = PH_DOWN;
            a_x_in     = ut - drv.cruise_end;
            a_y_in     = drv.total - ut;
            a_w1_in    = drv.span;
            a_w2_in    = ut - drv.cruise_end;
         end
      end else begin
         a_b_in = h;
         if (ut <= h) begin
            a_x_in = ut;
            a_y_in = ut;
         end else begin
            a_phase_in = PH_DOWN;
            a_x_in     = ut - h;
            a_y_in     = drv.total - ut;
         end
      end
   end

   // stage b: first products
   logic        b_valid_ff;
   logic [1:0]  b_kind_ff, b_phase_ff;
   logic [31:0] b_x_ff, b_b_ff;
   logic [62:0] b_ax_ff, b_ab_ff, b_ay_ff, b_v1_ff, b_v2_ff;

   // stage c: second partial products and speed
   logic        c_valid_ff;
   logic [1:0]  c_kind_ff, c_phase_ff;
   logic [63:0] c_rx_lo_ff, c_rb_lo_ff, c_mm_lo_ff;
   logic [62:0] c_rx_hi_ff, c_rb_hi_ff, c_mm_hi_ff;
   logic [30:0] c_vel_ff, c_vel_in;
   logic [63:0] c_l1_ff, c_l2_ff;
   logic [62:0] sp;

   assign sp = b_ay_ff >> FRAC_BITS;

   always_comb begin
      if (b_phase_ff == PH_MID) begin
         c_vel_in = v_eff;
      end else if (sp > 63'h7FFF_FFFF) begin
         c_vel_in = 31'h7FFF_FFFF;
      end else begin
         c_vel_in = sp[30:0];
      end
   end

   // stage d: assemble ramp terms
   logic        d_valid_ff;
   logic [1:0]  d_kind_ff, d_phase_ff;
   logic [63:0] d_rx_ff, d_rb_ff, d_lx_ff, d_l1_ff;
   logic [30:0] d_vel_ff;
   logic [95:0] rx_full, rb_full, mm_full;

   assign rx_full = 96'(c_rx_lo_ff) + (96'(c_rx_hi_ff) << 32);
   assign rb_full = 96'(c_rb_lo_ff) + (96'(c_rb_hi_ff) << 32);
   assign mm_full = 96'(c_mm_lo_ff) + (96'(c_mm_hi_ff) << 32);

   // stage e: sum of the base terms for the cruise and ramp-down phases
   logic        e_valid_ff;
   logic [1:0]  e_kind_ff, e_phase_ff;
   logic [63:0] e_rx_ff, e_sum_ff;
   logic [30:0] e_vel_ff;

   // stage f: displacement
   logic        f_valid_ff;
   logic [1:0]  f_kind_ff, f_phase_ff;
   logic [33:0] f_disp_ff, f_disp_in;
   logic [30:0] f_vel_ff;

   always_comb begin
      logic [63:0] disp;
      if (e_phase_ff == PH_UP) begin
         disp = e_rx_ff;
      end else if (e_phase_ff == PH_DOWN) begin
         disp = (e_rx_ff > e_sum_ff) ? 64'd0 : (e_sum_ff - e_rx_ff);
      end else begin
         disp = e_sum_ff;
      end
      f_disp_in = (disp > 64'(DISP_MAX)) ? DISP_MAX : disp[33:0];
   end

   // stage g: sign, saturate and select the end points
   logic               g_valid_ff;
   logic signed [31:0] g_pos_ff, g_pos_in;
   logic signed [31:0] g_vel_ff, g_vel_in;
   logic signed [31:0] g_acc_ff, g_acc_in;

   always_comb begin
      logic signed [34:0] p35;
      logic        [31:0] amag;
      logic               neg;
      p35  = drv.dir ? (35'(start_pos) - $signed({1'b0, f_disp_ff}))
                     : (35'(start_pos) + $signed({1'b0, f_disp_ff}));
      amag = {1'b0, a_eff};
      neg  = (f_phase_ff == PH_DOWN) ^ drv.dir;
      case (f_kind_ff)
         KIND_START: begin
            g_pos_in = start_pos;
            g_vel_in = '0;
            g_acc_in = '0;
         end
         KIND_END: begin
            g_pos_in = end_pos;
            g_vel_in = '0;
            g_acc_in = '0;
         end
         default: begin
            if (p35 > 35'sd2147483647) begin
               g_pos_in = 32'sh7FFF_FFFF;
            end else if (p35 < -35'sd2147483648) begin
               g_pos_in = 32'sh8000_0000;
            end else begin
               g_pos_in = p35[31:0];
            end
            g_vel_in = drv.dir ? (32'sd0 - $signed({1'b0, f_vel_ff}))
                               : $signed({1'b0, f_vel_ff});
            if (f_phase_ff == PH_MID) begin
               g_acc_in = '0;
            end else begin
               g_acc_in = neg ? (32'sd0 - $signed(amag)) : $signed(amag);
            end
         end
      endcase
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         f_valid_ff <= e_valid_ff;
         g_valid_ff <= f_valid_ff;
      end
   end

   // data path registers
   always_ff @(posedge clock) begin
      a_kind_ff  <= a_kind_in;
      a_phase_ff <= a_phase_in;
      a_x_ff     <= a_x_in;
      a_y_ff     <= a_y_in;
      a_b_ff     <= a_b_in;
      a_w1_ff    <= a_w1_in;
      a_w2_ff    <= a_w2_in;

      b_kind_ff  <= a_kind_ff;
      b_phase_ff <= a_phase_ff;
      b_x_ff     <= a_x_ff;
      b_b_ff     <= a_b_ff;
      b_ax_ff    <= 63'(a_eff) * 63'(a_x_ff);
      b_ab_ff    <= 63'(a_eff) * 63'(a_b_ff);
      b_ay_ff    <= 63'(a_eff) * 63'(a_y_ff);
      b_v1_ff    <= 63'(v_eff) * 63'(a_w1_ff);
      b_v2_ff    <= 63'(v_eff) * 63'(a_w2_ff);

      c_kind_ff  <= b_kind_ff;
      c_phase_ff <= b_phase_ff;
      c_rx_lo_ff <= 64'(b_ax_ff[31:0]) * 64'(b_x_ff);
      c_rx_hi_ff <= 63'(b_ax_ff[62:32]) * 63'(b_x_ff);
      c_rb_lo_ff <= 64'(b_ab_ff[31:0]) * 64'(b_b_ff);
      c_rb_hi_ff <= 63'(b_ab_ff[62:32]) * 63'(b_b_ff);
      c_mm_lo_ff <= 64'(b_ab_ff[31:0]) * 64'(b_x_ff);
      c_mm_hi_ff <= 63'(b_ab_ff[62:32]) * 63'(b_x_ff);
      c_vel_ff   <= c_vel_in;
      c_l1_ff    <= 64'(b_v1_ff >> FRAC_BITS);
      c_l2_ff    <= 64'(b_v2_ff >> FRAC_BITS);

      d_kind_ff  <= c_kind_ff;
      d_phase_ff <= c_phase_ff;
      d_rx_ff    <= mul_shift(rx_full, 2 * FRAC_BITS + 1);
      d_rb_ff    <= mul_shift(rb_full, 2 * FRAC_BITS + 1);
      d_lx_ff    <= drv.cruise ? c_l2_ff : mul_shift(mm_full, 2 * FRAC_BITS);
      d_l1_ff    <= c_l1_ff;
      d_vel_ff   <= c_vel_ff;

      e_kind_ff  <= d_kind_ff;
      e_phase_ff <= d_phase_ff;
      e_rx_ff    <= d_rx_ff;
      e_sum_ff   <= sat_add64(sat_add64(d_rb_ff, d_l1_ff), d_lx_ff);
      e_vel_ff   <= d_vel_ff;

      f_kind_ff  <= e_kind_ff;
      f_phase_ff <= e_phase_ff;
      f_disp_ff  <= f_disp_in;
      f_vel_ff   <= e_vel_ff;

      g_pos_ff   <= g_pos_in;
      g_vel_ff   <= g_vel_in;
      g_acc_ff   <= g_acc_in;
   end

   assign out_valid        = g_valid_ff;
   assign out_position     = g_pos_ff;
   assign out_velocity     = g_vel_ff;
   assign out_acceleration = g_acc_ff;

   // checks
   a_accept_ready : assert property (@(posedge clock) disable iff (reset)
      in_valid |-> drv.ready)
      else $error("sample taken before derived values are ready");
   a_latency : assert property (@(posedge clock) disable iff (reset)
      g_valid_ff |-> $past(a_valid_ff, 6))
      else $error("result beat without a matching sample");
   a_disp_clamp : assert property (@(posedge clock) disable iff (reset)
      f_valid_ff |-> f_disp_ff <= DISP_MAX)
      else $error("displacement beyond clamp");

endmodule

/* rtl/trapezoid_profile_evaluator_top.sv */
// ----------------------------------------------------------------------------
// trapezoid_profile_evaluator_top
// A result beat leaves the seven registered stages a to g of the evaluation
// pipe after the edge that takes start; throughput is one sample per cycle
// while busy is low. After reset or a write to a configuration register busy
// stays high while the bit-serial divider and square root rework the derived
// times. No back-pressure.
// ----------------------------------------------------------------------------
module trapezoid_profile_evaluator_top import tpe_pkg::*; #(
   parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_sample_time,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_position,
   output logic signed [31:0]   rsp_velocity,
   output logic signed [31:0]   rsp_acceleration,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam logic [30:0] TENTH_Q = 31'((((64'd1) << FRAC_BITS) + 64'd5) / 64'd10);

   logic signed [31:0] start_pos_ff, start_pos_in;
   logic signed [31:0] end_pos_ff, end_pos_in;
   logic        [30:0] speed_ff, speed_in;
   logic        [30:0] accel_ff, accel_in;
   logic               cfg_hit;
   logic        [30:0] v_eff, a_eff;
   derived_type        drv;

   // register writes
   always_comb begin
      start_pos_in = start_pos_ff;
      end_pos_in   = end_pos_ff;
      speed_in     = speed_ff;
      accel_in     = accel_ff;
      cfg_hit      = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            REG_START_POS: begin
               start_pos_in = csr_wdata;
               cfg_hit      = 1'b1;
            end
            REG_END_POS: begin
               end_pos_in = csr_wdata;
               cfg_hit    = 1'b1;
            end
            REG_SPEED: begin
               speed_in = csr_wdata[30:0];
               cfg_hit  = 1'b1;
            end
            REG_ACCEL: begin
               accel_in = csr_wdata[30:0];
               cfg_hit  = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_pos_ff <= '0;
         end_pos_ff   <= '0;
         speed_ff     <= LIMIT_RESET;
         accel_ff     <= LIMIT_RESET;
      end else begin
         start_pos_ff <= start_pos_in;
         end_pos_ff   <= end_pos_in;
         speed_ff     <= speed_in;
         accel_ff     <= accel_in;
      end
   end

   assign csr_ready = 1'b1;

   // a zero limit stands for one tenth
   assign v_eff = (speed_ff == '0) ? TENTH_Q : speed_ff;
   assign a_eff = (accel_ff == '0) ? TENTH_Q : accel_ff;

   tpe_derive #(
      .FRAC_BITS (FRAC_BITS)
   ) u_derive (
      .clock     (clock),
      .reset     (reset),
      .restart   (cfg_hit),
      .start_pos (start_pos_ff),
      .end_pos   (end_pos_ff),
      .v_eff     (v_eff),
      .a_eff     (a_eff),
      .drv       (drv)
   );

   assign busy = ~drv.ready;

   tpe_eval #(
      .FRAC_BITS (FRAC_BITS)
   ) u_eval (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (start & ~busy),
      .in_time          (req_sample_time),
      .drv              (drv),
      .a_eff            (a_eff),
      .v_eff            (v_eff),
      .start_pos        (start_pos_ff),
      .end_pos          (end_pos_ff),
      .out_valid        (rsp_valid),
      .out_position     (rsp_position),
      .out_velocity     (rsp_velocity),
      .out_acceleration (rsp_acceleration)
   );

endmodule

/* bench/tpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpe_checker
// Watches the register, sample and result channels of the trapezoid profile
// evaluator, keeps its own copy of the move and its derived times, predicts
// position, velocity and acceleration for every accepted sample and compares
// each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tpe_checker import tpe_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic signed [31:0]   req_sample_time,
   input  logic                 rsp_valid,
   input  logic signed [31:0]   rsp_position,
   input  logic signed [31:0]   rsp_velocity,
   input  logic signed [31:0]   rsp_acceleration,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata,
   output int                   errors,
   output int                   pending
);

   localparam int unsigned FB = FRAC_BITS_DEF;
   localparam bit [63:0] TENTH = ((64'd1 << FB) + 64'd5) / 64'd10;
   localparam bit [63:0] MAX32 = 64'hFFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] acc;
   } motion_type;

   // move description as last written
   longint    start_pos, end_pos;
   bit [63:0] speed_raw, accel_raw;

   // derived times
   bit [63:0] travel_len, ramp_t, total_t;
   bit        dir_neg, cruise, derived_ok;

   motion_type expected_motion[$];

   function automatic bit [63:0] limit_of(bit [63:0] raw);
      return (raw == 0) ? TENTH : raw;
   endfunction

   function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

   // exact 128-bit product shifted right, saturated to 64 bits
   function automatic bit [63:0] prod_shift(bit [63:0] x, bit [63:0] y, int unsigned s);
      bit [127:0] p;
      p = {64'd0, x} * {64'd0, y};
      if ((p >> (64 + s)) != 0) return {64{1'b1}};
      return 64'(p >> s);
   endfunction

   function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // a * x^2 / 2
   function automatic bit [63:0] ramp_travel(bit [63:0] a, bit [63:0] x);
      return prod_shift(a * x, x, 2 * FB + 1);
   endfunction

   function automatic bit [63:0] ramp_speed(bit [63:0] a, bit [63:0] x);
      bit [63:0] s;
      s = (a * x) >> FB;
      return (s > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : s;
   endfunction

   // ramp time, total time and profile shape for the current move
   task automatic work_out_times();
      bit [63:0] a, v, q, tot, q2;
      longint    diff;
      a = limit_of(accel_raw);
      v = limit_of(speed_raw);
      diff = end_pos - start_pos;
      dir_neg = (diff < 0);
      travel_len = dir_neg ? 64'(-diff) : 64'(diff);
      q = (v << FB) / a;
      ramp_t = (q > MAX32) ? MAX32 : q;
      cruise = (travel_len * a) > (v * v);
      if (cruise) begin
         tot = ramp_t + (travel_len << FB) / v;
      end else begin
         q2 = (travel_len << FB) / a;
         if (q2 >= (64'd1 << (62 - FB))) tot = MAX32;
         else tot = 2 * int_sqrt(q2 << FB);
      end
      total_t = (tot > MAX32) ? MAX32 : tot;
      derived_ok = 1'b1;
   endtask

   task automatic profile_at(input logic signed [31:0] ts, output motion_type m);
      longint    t, pos, sv, sa;
      bit [63:0] a, v, ut, disp, vel, ce, dt, span, sub, h;
      int        sgn;
      if (!derived_ok) work_out_times();
      a = limit_of(accel_raw);
      v = limit_of(speed_raw);
      t = longint'(ts);
      if (t <= 0 || 64'(t) >= total_t) begin
         m.pos = (t <= 0) ? start_pos[31:0] : end_pos[31:0];
         m.vel = '0;
         m.acc = '0;
         return;
      end
      ut = 64'(t);
      if (cruise) begin
         ce = (total_t >= ramp_t) ? total_t - ramp_t : 0;
         if (ut <= ramp_t) begin
            sgn = 1;
            vel = ramp_speed(a, ut);
            disp = ramp_travel(a, ut);
         end else if (ut <= ce) begin
            sgn = 0;
            vel = v;
            disp = add_sat(ramp_travel(a, ramp_t), (v * (ut - ramp_t)) >> FB);
         end else begin
            dt = ut - ce;
            span = (total_t >= 2 * ramp_t) ? total_t - 2 * ramp_t : 0;
            sub = ramp_travel(a, dt);
            sgn = -1;
            vel = ramp_speed(a, total_t - ut);
            disp = add_sat(ramp_travel(a, ramp_t), (v * span) >> FB);
            disp = add_sat(disp, (v * dt) >> FB);
            disp = (sub > disp) ? 0 : disp - sub;
         end
      end else begin
         h = total_t >> 1;
         if (ut <= h) begin
            sgn = 1;
            vel = ramp_speed(a, ut);
            disp = ramp_travel(a, ut);
         end else begin
            dt = ut - h;
            sub = ramp_travel(a, dt);
            sgn = -1;
            vel = ramp_speed(a, total_t - ut);
            disp = add_sat(ramp_travel(a, h), prod_shift(a * h, dt, 2 * FB));
            disp = (sub > disp) ? 0 : disp - sub;
         end
      end
      if (disp > (64'd1 << 33)) disp = 64'd1 << 33;
      if (dir_neg) begin
         pos = start_pos - longint'(disp);
         sv = -longint'(vel);
         sgn = -sgn;
      end else begin
         pos = start_pos + longint'(disp);
         sv = longint'(vel);
      end
      if (pos > 64'sd2147483647) pos = 64'sd2147483647;
      if (pos < -64'sd2147483648) pos = -64'sd2147483648;
      sa = longint'(sgn) * longint'(a);
      m.pos = pos[31:0];
      m.vel = sv[31:0];
      m.acc = sa[31:0];
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %0t: %s got %h expected %h", $time, what, got, want);
      errors++;
   endtask

   // track writes, predict on accepted samples, compare result beats
   always @(posedge clock) begin
      motion_type m, e;
      if (reset) begin
         start_pos = 0;
         end_pos = 0;
         speed_raw = 64'(LIMIT_RESET);
         accel_raw = 64'(LIMIT_RESET);
         derived_ok = 1'b0;
         cruise = 1'b0;
         dir_neg = 1'b0;
         travel_len = 0;
         ramp_t = 0;
         total_t = 0;
         expected_motion.delete();
         errors = 0;
         pending = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_motion.size() == 0) begin
               report_mismatch("unexpected beat", rsp_position, '0);
            end else begin
               e = expected_motion.pop_front();
               if (rsp_position !== e.pos) report_mismatch("position", rsp_position, e.pos);
               if (rsp_velocity !== e.vel) report_mismatch("velocity", rsp_velocity, e.vel);
               if (rsp_acceleration !== e.acc)
                  report_mismatch("acceleration", rsp_acceleration, e.acc);
            end
         end
         if (start && !busy) begin
            profile_at(req_sample_time, m);
            expected_motion = {expected_motion, m};
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_POS: begin
                  start_pos = longint'($signed(csr_wdata));
                  derived_ok = 1'b0;
               end
               REG_END_POS: begin
                  end_pos = longint'($signed(csr_wdata));
                  derived_ok = 1'b0;
               end
               REG_SPEED: begin
                  speed_raw = 64'(csr_wdata[30:0]);
                  derived_ok = 1'b0;
               end
               REG_ACCEL: begin
                  accel_raw = 64'(csr_wdata[30:0]);
                  derived_ok = 1'b0;
               end
               default: ;
            endcase
         end
         pending = expected_motion.size();
      end
   end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register settings and sample times into the trapezoid profile
// evaluator: a directed pass over extremes and each profile shape, then
// random moves with random samples and random gaps. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import tpe_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd4;
   localparam int LIMIT_CYCLES = 400000;
   localparam int ONE = 65536;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic signed [31:0]   req_sample_time = '0;
   logic                 rsp_valid;
   logic signed [31:0]   rsp_position, rsp_velocity, rsp_acceleration;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   int                   errors, pending;
   int                   cycles = 0;
   bit                   no_gaps = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   trapezoid_profile_evaluator_top dut (.*);

   tpe_checker u_checker (.*);

   // overall run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("** trapezoid_profile_evaluator_top: FAILED **");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // wait for every expected beat, then let the pipe run empty
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic set_move(int sp, int ep, logic [31:0] spd, logic [31:0] acc);
      drain();
      write_reg(REG_START_POS, sp);
      write_reg(REG_END_POS, ep);
      write_reg(REG_SPEED, spd);
      write_reg(REG_ACCEL, acc);
   endtask

   // one sample beat, with a random gap ahead of it
   task automatic send_sample(logic [31:0] t);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_sample_time <= t;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_time();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r == 1) return -$urandom_range(0, 4 * ONE);
      if (r == 2) return $urandom_range(0, 3);
      return $urandom_range(0, 1 << 22);
   endfunction

   initial begin
      logic [31:0] spd, acc;
      int          sp;
      logic [31:0] probe [9];
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset setting: zero distance
      send_sample(32'h8000_0000);
      send_sample(0);
      send_sample(1);
      send_sample(32'h7FFF_FFFF);
      start <= 1'b0;

      // trapezoid: 4.0 units at 1.0 speed and accel
      set_move(0, 4 * ONE, ONE, ONE);
      probe = '{-1, 1, ONE / 2, ONE, 2 * ONE, 4 * ONE + ONE / 2, 5 * ONE - 1,
                5 * ONE, 32'h7FFF_FFFF};
      foreach (probe[i])
         send_sample(probe[i]);
      start <= 1'b0;

      // triangle, backwards, then zero limits, then the widest move
      set_move(ONE, -ONE, 4 * ONE, ONE);
      send_sample(ONE);
      send_sample(2 * ONE);
      send_sample(3 * ONE);
      start <= 1'b0;
      set_move(0, ONE, 0, 0);
      send_sample(5 * ONE);
      send_sample(20 * ONE);
      start <= 1'b0;
      set_move(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_sample(ONE);
      send_sample(2);
      start <= 1'b0;
      drain();
      write_reg(REG_SPARE + 3'($urandom_range(0, 3)), $urandom);

      // random moves
      for (int ph = 0; ph < 12; ph++) begin
         no_gaps = (ph % 4 == 2);
         spd = (ph % 5 == 0) ? 0 : $urandom_range(ONE / 4, 4 * ONE) | ($urandom << 31);
         acc = (ph % 6 == 1) ? 0 : $urandom_range(ONE / 4, 4 * ONE) | ($urandom << 31);
         sp = $urandom_range(0, 3) == 0 ? int'($urandom) : $urandom_range(0, 64 * ONE) - 32 * ONE;
         if (ph == 11) begin
            spd = 32'h7FFF_FFFF;
            acc = 32'h7FFF_FFFF;
         end
         set_move(sp, sp + $urandom_range(0, 32 * ONE) - 16 * ONE, spd, acc);
         if (ph == 7) write_reg(REG_SPARE + 3'($urandom_range(0, 3)), $urandom);
         for (int n = 0; n < 118; n++) send_sample(pick_time());
         start <= 1'b0;
      end

      // wait out the last beats
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("** trapezoid_profile_evaluator_top: PASSED **");
      else
         $display("** trapezoid_profile_evaluator_top: FAILED **");
      $finish;
   end

endmodule
